FILE: src/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types, sizes and helper functions of the ternary match table.
// ----------------------------------------------------------------------------
package tmt_pkg;

  // Table geometry.
  localparam int unsigned Depth     = 64;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned OutW      = 32;
  localparam int unsigned IdxW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned KbW       = 4;

  // Operation codes of an input transaction.
  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // Register map.
  localparam int unsigned AddrW       = 3;
  localparam logic        RegKeyBytes = 1'b0;
  localparam logic [KbW-1:0] KeyBytesReset = KbW'(8);

  // One stored entry.
  typedef struct packed {
    logic [KeyW-1:0]      key;
    logic [KeyW-1:0]      mask;
    logic [ValueBits-1:0] value;
  } tmt_entry_t;

  localparam int unsigned EntryW = $bits(tmt_entry_t);

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StRead,
    StCompare,
    StResult
  } tmt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_item;
    logic write_entry;
    logic init_scan;
    logic rd_en;
    logic dec_idx;
    logic set_hit;
    logic set_status;
    logic load_out;
  } tmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic full;
    logic empty;
    logic match;
    logic idx_zero;
  } tmt_sts_t;

  // Bit mask of the compared low key bytes; counts above eight act as eight.
  function automatic logic [KeyW-1:0] tmt_compare_mask(input logic [KbW-1:0] kb);
    logic [KbW-1:0]  nb;
    logic [KeyW-1:0] m;
    nb = (kb > KbW'(8)) ? KbW'(8) : kb;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (KbW'(b) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: src/tmt_ram.sv
// ----------------------------------------------------------------------------
// tmt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tmt_ctrl.sv
// ----------------------------------------------------------------------------
// tmt_ctrl
// Controller of the ternary match table: sequences adds, lookup scans and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module tmt_ctrl import tmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  tmt_sts_t sts_i,
  output tmt_cmd_t cmd_o
);

  tmt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          state_d        = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.is_add) begin
          if (sts_i.full) begin
            cmd_o.set_status = 1'b1;
          end else begin
            cmd_o.write_entry = 1'b1;
          end
          state_d = StResult;
        end else if (sts_i.empty) begin
          state_d = StResult;
        end else begin
          cmd_o.init_scan = 1'b1;
          state_d         = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StCompare;
      end
      StCompare: begin
        if (sts_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d       = StResult;
        end else if (sts_i.idx_zero) begin
          state_d = StResult;
        end else begin
          cmd_o.dec_idx = 1'b1;
          state_d       = StRead;
        end
      end
      StResult: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/tmt_datapath.sv
// ----------------------------------------------------------------------------
// tmt_datapath
// Datapath of the ternary match table: item registers, entry count, scan
// index, entry memory, masked comparator and result registers.
// ----------------------------------------------------------------------------
module tmt_datapath import tmt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmt_cmd_t             cmd_i,
  output tmt_sts_t             sts_o,
  input  logic [KbW-1:0]       key_bytes_i,
  input  logic                 cmd_in_i,
  input  logic [KeyW-1:0]      key_i,
  input  logic [KeyW-1:0]      mask_i,
  input  logic [OutW-1:0]      value_i,
  output logic                 hit_o,
  output logic [OutW-1:0]      found_value_o,
  output logic                 status_o
);

  // Captured transaction.
  logic            op_q;
  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] mask_q;
  logic [OutW-1:0] value_q;

  // Working result and output register.
  logic            hit_q, status_q;
  logic [OutW-1:0] found_q;
  logic            out_hit_q, out_status_q;
  logic [OutW-1:0] out_found_q;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;

  tmt_entry_t wr_entry, rd_entry;
  logic [EntryW-1:0] rd_data;
  logic [KeyW-1:0]   cmp_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.write_entry) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      op_q     <= cmd_in_i;
      key_q    <= key_i;
      mask_q   <= mask_i;
      value_q  <= value_i;
      hit_q    <= 1'b0;
      status_q <= 1'b0;
      found_q  <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= 1'b1;
    end
    if (cmd_i.set_hit) begin
      hit_q   <= 1'b1;
      found_q <= OutW'(rd_entry.value);
    end
    if (cmd_i.init_scan) begin
      idx_q <= IdxW'(count_q - CntW'(1));
    end else if (cmd_i.dec_idx) begin
      idx_q <= idx_q - IdxW'(1);
    end
    if (cmd_i.load_out) begin
      out_hit_q    <= hit_q;
      out_found_q  <= found_q;
      out_status_q <= status_q;
    end
  end

  always_comb begin
    wr_entry.key   = key_q;
    wr_entry.mask  = mask_q;
    wr_entry.value = ValueBits'(value_q);
  end

  tmt_ram #(
    .WIDTH(EntryW),
    .DEPTH(Depth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_entry),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(wr_entry),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q),
    .rdata_o(rd_data)
  );

  assign rd_entry = tmt_entry_t'(rd_data);
  assign cmp_mask = tmt_compare_mask(key_bytes_i);

  always_comb begin
    sts_o.is_add   = (op_q == CmdAdd);
    sts_o.full     = (count_q == CntW'(Depth));
    sts_o.empty    = (count_q == '0);
    sts_o.match    = (((rd_entry.key ^ (key_q & rd_entry.mask)) & cmp_mask) == '0);
    sts_o.idx_zero = (idx_q == '0);
  end

  assign hit_o         = out_hit_q;
  assign found_value_o = out_found_q;
  assign status_o      = out_status_q;

endmodule

FILE: src/ternary_match_table.sv
// ----------------------------------------------------------------------------
// ternary_match_table
// Ternary match table with insertion-order priority and an APB-style
// configuration port.
// ----------------------------------------------------------------------------
// An add transaction (cmd 0) appends key, mask and value at the next free
// slot; once all 64 slots are used an add is refused with status 1 and
// nothing is stored. A lookup transaction (cmd 1) searches the stored entries
// from the most recently added one backward and stops at the first entry
// whose stored key equals the search key ANDed with that entry's mask, over
// the low key_bytes bytes (register at byte address 0, reset 8, values above
// eight act as eight, zero makes every entry match). Each transaction gives
// exactly one result: hit and found_value for a lookup, status for an add.
// The block handles one transaction at a time. An add passes from acceptance
// through a decode state to the result state. A lookup decodes, then reads and
// compares one entry at a time, newest first, until a match or the oldest
// entry (an empty table skips this scan), then enters the result state; the
// entry memory has a single registered read port feeding a single masked
// comparator. A finished result sits in an output register, and the next
// transaction can be accepted while it waits there to be taken. The entry
// memory has no reset; only entries below the entry count are ever read.
// ----------------------------------------------------------------------------
module ternary_match_table import tmt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input transactions.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [KeyW-1:0]   mask_i,
  input  logic [OutW-1:0]   value_i,
  // Result transactions.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [OutW-1:0]   found_value_o,
  output logic              status_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  tmt_cmd_t       cmd;
  tmt_sts_t       sts;
  logic [KbW-1:0] key_bytes_q;
  logic           reg_sel;

  // Only one register exists; bit 2 of the byte address selects it.
  assign reg_sel = (paddr[2] == RegKeyBytes);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= KeyBytesReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      key_bytes_q <= pwdata[KbW-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - KbW){1'b0}}, key_bytes_q} : '0;

  tmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .key_bytes_i  (key_bytes_q),
    .cmd_in_i     (cmd_i),
    .key_i        (key_i),
    .mask_i       (mask_i),
    .value_i      (value_i),
    .hit_o        (hit_o),
    .found_value_o(found_value_o),
    .status_o     (status_o)
  );

endmodule
